// File: rtl/core/at2_pkg.sv
`timescale 1ns / 1ps
// at2_pkg: shared widths, Q15 polynomial coefficients and Q32 angle constants
// for the atan2 pipeline. No dependencies.
package at2_pkg;

    localparam int IN_WIDTH_DEF        = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 13;

    // ratio a is unsigned Q1.16, so the divider yields 17 quotient bits
    localparam int A_BITS = 17;
    // polynomial terms, signed Q16
    localparam int T_BITS = 18;
    // octant-corrected angle, signed Q32
    localparam int R_BITS = 40;

    localparam logic signed [T_BITS-1:0] C3   = -18'sd1524;
    localparam logic signed [T_BITS-1:0] C2X2 = 18'sd10440;
    localparam logic signed [T_BITS-1:0] C1X2 = 18'sd21472;

    localparam logic signed [63:0] HALF_PI_Q32 = 64'sd6746518852;
    localparam logic signed [63:0] PI_Q32      = 64'sd13493037705;

    localparam logic signed [R_BITS-1:0] K_HALF_PI = R_BITS'(HALF_PI_Q32);
    localparam logic signed [R_BITS-1:0] K_PI      = R_BITS'(PI_Q32);
    localparam logic signed [R_BITS-1:0] K_PI_MH   = R_BITS'(PI_Q32 - HALF_PI_Q32);

    typedef struct packed {
        logic swap;
        logic x_neg;
        logic y_neg;
        logic zero;
    } at2_oct_t;

    // pi in Q32 rounded half up to frac fraction bits
    function automatic logic signed [63:0] at2_pi_lim(input int frac);
        logic signed [63:0] half;
        half = 64'sd1 <<< (31 - frac);
        return (PI_Q32 + half) >>> (32 - frac);
    endfunction

endpackage

// File: rtl/core/at2_div_cell.sv
`timescale 1ns / 1ps
// at2_div_cell: one restoring-division cell, produces one quotient bit per beat.
// Depends on at2_pkg.
module at2_div_cell
    import at2_pkg::*;
#(
    parameter int IN_WIDTH = IN_WIDTH_DEF,
    parameter bit FIRST    = 1'b0
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                up_valid,
    output logic                up_ready,
    input  logic [IN_WIDTH-1:0] up_rem,
    input  logic [IN_WIDTH-1:0] up_mx,
    input  logic [A_BITS-1:0]   up_quo,
    input  at2_oct_t            up_oct,
    output logic                dn_valid,
    input  logic                dn_ready,
    output logic [IN_WIDTH-1:0] dn_rem,
    output logic [IN_WIDTH-1:0] dn_mx,
    output logic [A_BITS-1:0]   dn_quo,
    output at2_oct_t            dn_oct
);

    logic                valid_reg;
    logic [IN_WIDTH-1:0] rem_reg;
    logic [IN_WIDTH-1:0] mx_reg;
    logic [A_BITS-1:0]   quo_reg;
    at2_oct_t            oct_reg;

    logic                ready;
    logic [IN_WIDTH-1:0] trial;
    logic                take;
    logic [IN_WIDTH-1:0] rem_next;
    logic [A_BITS-1:0]   quo_next;

    assign ready    = !valid_reg || dn_ready;
    assign up_ready = ready;

    // remainder stays below the divisor, so doubling never overflows
    assign trial    = FIRST ? up_rem : {up_rem[IN_WIDTH-2:0], 1'b0};
    assign take     = (trial >= up_mx);
    assign rem_next = take ? (trial - up_mx) : trial;
    assign quo_next = {up_quo[A_BITS-2:0], take};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && up_valid)
        begin
            rem_reg <= rem_next;
            mx_reg  <= up_mx;
            quo_reg <= quo_next;
            oct_reg <= up_oct;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_rem   = rem_reg;
    assign dn_mx    = mx_reg;
    assign dn_quo   = quo_reg;
    assign dn_oct   = oct_reg;

endmodule

// File: rtl/core/at2_poly.sv
`timescale 1ns / 1ps
// at2_poly: five-stage evaluation of the odd atan polynomial on the Q16 ratio.
// Depends on at2_pkg.
module at2_poly
    import at2_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     up_valid,
    output logic                     up_ready,
    input  logic [A_BITS-1:0]        up_quo,
    input  at2_oct_t                 up_oct,
    output logic                     dn_valid,
    input  logic                     dn_ready,
    output logic signed [T_BITS-1:0] dn_t,
    output at2_oct_t                 dn_oct
);

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic r1, r2, r3, r4, r5;

    logic [A_BITS-1:0]        a1_reg, a2_reg, a3_reg, a4_reg;
    logic [A_BITS-1:0]        s1_reg, s2_reg, s3_reg;
    logic signed [T_BITS-1:0] t2_reg, t3_reg, t4_reg, t5_reg;
    at2_oct_t                 oct1_reg, oct2_reg, oct3_reg, oct4_reg, oct5_reg;

    logic [A_BITS-1:0]        a1_next;
    logic [2*A_BITS-1:0]      sq1;
    logic [A_BITS-1:0]        s1_next;
    logic signed [35:0]       p2, p3, p4, p5;
    logic signed [36:0]       q2, q3, q4, q5;
    logic signed [T_BITS-1:0] t2_next, t3_next, t4_next, t5_next;

    assign r5 = !v5_reg || dn_ready;
    assign r4 = !v4_reg || r5;
    assign r3 = !v3_reg || r4;
    assign r2 = !v2_reg || r3;
    assign r1 = !v1_reg || r2;
    assign up_ready = r1;

    // stage 1: a and s = a*a
    assign a1_next = up_oct.zero ? '0 : up_quo;
    assign sq1     = a1_next * a1_next;
    assign s1_next = A_BITS'((35'(sq1) + 35'd32768) >> 16);

    // stage 2: c3*s + c2
    assign p2      = C3 * $signed({1'b0, s1_reg});
    assign q2      = (37'(p2) + 37'sd16384) >>> 15;
    assign t2_next = T_BITS'(q2) + C2X2;

    // stage 3: (...)*s - c1
    assign p3      = t2_reg * $signed({1'b0, s2_reg});
    assign q3      = (37'(p3) + 37'sd32768) >>> 16;
    assign t3_next = T_BITS'(q3) - C1X2;

    // stage 4: (...)*s
    assign p4      = t3_reg * $signed({1'b0, s3_reg});
    assign q4      = (37'(p4) + 37'sd32768) >>> 16;
    assign t4_next = T_BITS'(q4);

    // stage 5: (...)*a + a
    assign p5      = t4_reg * $signed({1'b0, a4_reg});
    assign q5      = (37'(p5) + 37'sd32768) >>> 16;
    assign t5_next = T_BITS'(q5) + $signed({1'b0, a4_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (r1) v1_reg <= up_valid;
            if (r2) v2_reg <= v1_reg;
            if (r3) v3_reg <= v2_reg;
            if (r4) v4_reg <= v3_reg;
            if (r5) v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r1 && up_valid)
        begin
            a1_reg   <= a1_next;
            s1_reg   <= s1_next;
            oct1_reg <= up_oct;
        end
        if (r2 && v1_reg)
        begin
            a2_reg   <= a1_reg;
            s2_reg   <= s1_reg;
            t2_reg   <= t2_next;
            oct2_reg <= oct1_reg;
        end
        if (r3 && v2_reg)
        begin
            a3_reg   <= a2_reg;
            s3_reg   <= s2_reg;
            t3_reg   <= t3_next;
            oct3_reg <= oct2_reg;
        end
        if (r4 && v3_reg)
        begin
            a4_reg   <= a3_reg;
            t4_reg   <= t4_next;
            oct4_reg <= oct3_reg;
        end
        if (r5 && v4_reg)
        begin
            t5_reg   <= t5_next;
            oct5_reg <= oct4_reg;
        end
    end

    assign dn_valid = v5_reg;
    assign dn_t     = t5_reg;
    assign dn_oct   = oct5_reg;

endmodule

// File: rtl/core/at2_fixup.sv
`timescale 1ns / 1ps
// at2_fixup: octant correction, rounding, clamp to +/-pi and sign of y;
// holds the output register. Depends on at2_pkg.
module at2_fixup
    import at2_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              up_valid,
    output logic                              up_ready,
    input  logic signed [T_BITS-1:0]          up_t,
    input  at2_oct_t                          up_oct,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [ANGLE_FRAC_BITS+2:0] angle
);

    localparam int SH = 32 - ANGLE_FRAC_BITS;
    localparam logic signed [R_BITS-1:0] RND = R_BITS'(64'sd1 <<< (SH - 1));
    localparam logic signed [R_BITS-1:0] LIM = R_BITS'(at2_pi_lim(ANGLE_FRAC_BITS));

    logic                              v1_reg;
    logic                              valid_reg;
    logic signed [R_BITS-1:0]          r_reg;
    logic                              y_neg_reg;
    logic signed [ANGLE_FRAC_BITS+2:0] angle_reg;

    logic                              r1, r2;
    logic signed [R_BITS-1:0]          t_q32;
    logic signed [R_BITS-1:0]          r_next;
    logic signed [R_BITS-1:0]          m;
    logic signed [R_BITS-1:0]          mc;
    logic signed [R_BITS-1:0]          ms;
    logic signed [ANGLE_FRAC_BITS+2:0] angle_next;

    assign r2       = !valid_reg || !out_stall;
    assign r1       = !v1_reg || r2;
    assign up_ready = r1;

    assign t_q32 = R_BITS'(up_t) <<< 16;

    always_comb
    begin
        case ({up_oct.swap, up_oct.x_neg})
            2'b10:   r_next = K_HALF_PI - t_q32;
            2'b01:   r_next = K_PI - t_q32;
            2'b11:   r_next = K_PI_MH + t_q32;
            default: r_next = t_q32;
        endcase
    end

    assign m  = (r_reg + RND) >>> SH;
    assign mc = (m > LIM) ? LIM : ((m < -LIM) ? -LIM : m);
    assign ms = y_neg_reg ? -mc : mc;
    assign angle_next = ms[ANGLE_FRAC_BITS+2:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (r1) v1_reg <= up_valid;
            if (r2) valid_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r1 && up_valid)
        begin
            r_reg     <= r_next;
            y_neg_reg <= up_oct.y_neg;
        end
        if (r2 && v1_reg)
        begin
            angle_reg <= angle_next;
        end
    end

    assign out_valid = valid_reg;
    assign angle     = angle_reg;

endmodule

// File: rtl/core/atan2_polynomial_approx_top.sv
`timescale 1ns / 1ps
// atan2_polynomial_approx_top: four-quadrant arctangent, one angle per beat.
// Depends on at2_pkg, at2_div_cell, at2_poly, at2_fixup.
//
// Usage:
//   Input channel: in_valid / in_stall with y_value and x_value (signed).
//   A beat is taken on a rising edge with in_valid high and in_stall low.
//   Output channel: out_valid / out_stall with angle, signed Q3.ANGLE_FRAC_BITS
//   radians within [-pi, +pi]. A beat leaves when out_valid is high and
//   out_stall is low.
//   Pipeline: 1 magnitude/octant stage, 17 divider cells, one per
//   quotient bit of the Q1.16 ratio, 5 polynomial stages, 2 correction
//   stages. Throughput: one beat per cycle while out_stall is low, set by
//   the divider cell chain and the one-multiplier polynomial stages.
//   Every stage advances when it is empty or its successor advances, so
//   bubbles collapse; when the receiver stalls, results back up stage by
//   stage and in_stall rises only once every stage holds a beat.
//   Reset empties the pipeline; out_valid is low and in_stall low after it.
module atan2_polynomial_approx_top
    import at2_pkg::*;
#(
    parameter int IN_WIDTH        = IN_WIDTH_DEF,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [IN_WIDTH-1:0]        y_value,
    input  logic signed [IN_WIDTH-1:0]        x_value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [ANGLE_FRAC_BITS+2:0] angle
);

    logic                prep_valid_reg;
    logic [IN_WIDTH-1:0] prep_mn_reg;
    logic [IN_WIDTH-1:0] prep_mx_reg;
    at2_oct_t            prep_oct_reg;

    logic                prep_ready;
    logic [IN_WIDTH-1:0] ay;
    logic [IN_WIDTH-1:0] ax;
    logic [IN_WIDTH-1:0] mn_next;
    logic [IN_WIDTH-1:0] mx_next;
    at2_oct_t            oct_next;

    logic                div_valid [A_BITS+1];
    logic                div_ready [A_BITS+1];
    logic [IN_WIDTH-1:0] div_rem   [A_BITS+1];
    logic [IN_WIDTH-1:0] div_mx    [A_BITS+1];
    logic [A_BITS-1:0]   div_quo   [A_BITS+1];
    at2_oct_t            div_oct   [A_BITS+1];

    logic                     poly_valid;
    logic                     poly_ready;
    logic signed [T_BITS-1:0] poly_t;
    at2_oct_t                 poly_oct;

    // magnitudes; the most negative input maps to 2^(IN_WIDTH-1) exactly
    assign ay = y_value[IN_WIDTH-1] ? (~y_value + 1'b1) : y_value;
    assign ax = x_value[IN_WIDTH-1] ? (~x_value + 1'b1) : x_value;

    assign oct_next.swap  = (ay > ax);
    assign oct_next.x_neg = x_value[IN_WIDTH-1];
    assign oct_next.y_neg = y_value[IN_WIDTH-1];
    assign oct_next.zero  = (x_value == '0) && (y_value == '0);
    assign mx_next = oct_next.swap ? ay : ax;
    assign mn_next = oct_next.swap ? ax : ay;

    assign prep_ready = !prep_valid_reg || div_ready[0];
    assign in_stall   = !prep_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_valid_reg <= 1'b0;
        end
        else if (prep_ready)
        begin
            prep_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (prep_ready && in_valid)
        begin
            prep_mn_reg  <= mn_next;
            prep_mx_reg  <= mx_next;
            prep_oct_reg <= oct_next;
        end
    end

    assign div_valid[0] = prep_valid_reg;
    assign div_rem[0]   = prep_mn_reg;
    assign div_mx[0]    = prep_mx_reg;
    assign div_quo[0]   = '0;
    assign div_oct[0]   = prep_oct_reg;

    for (genvar k = 0; k < A_BITS; k++)
    begin : g_div
        at2_div_cell #(
            .IN_WIDTH (IN_WIDTH),
            .FIRST    (k == 0)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (div_valid[k]),
            .up_ready (div_ready[k]),
            .up_rem   (div_rem[k]),
            .up_mx    (div_mx[k]),
            .up_quo   (div_quo[k]),
            .up_oct   (div_oct[k]),
            .dn_valid (div_valid[k+1]),
            .dn_ready (div_ready[k+1]),
            .dn_rem   (div_rem[k+1]),
            .dn_mx    (div_mx[k+1]),
            .dn_quo   (div_quo[k+1]),
            .dn_oct   (div_oct[k+1])
        );
    end

    at2_poly u_poly (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (div_valid[A_BITS]),
        .up_ready (div_ready[A_BITS]),
        .up_quo   (div_quo[A_BITS]),
        .up_oct   (div_oct[A_BITS]),
        .dn_valid (poly_valid),
        .dn_ready (poly_ready),
        .dn_t     (poly_t),
        .dn_oct   (poly_oct)
    );

    at2_fixup #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_fixup (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (poly_valid),
        .up_ready  (poly_ready),
        .up_t      (poly_t),
        .up_oct    (poly_oct),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .angle     (angle)
    );

endmodule

// File: rtl/core/at2_checker.sv
`timescale 1ns / 1ps
// at2_checker: port-level checks of the atan2 top level, bound to it below.
// Depends on at2_pkg.
module at2_checker
    import at2_pkg::*;
#(
    parameter int IN_WIDTH        = IN_WIDTH_DEF,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
)
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic signed [ANGLE_FRAC_BITS+2:0] angle
);

    localparam logic signed [ANGLE_FRAC_BITS+2:0] LIM =
        (ANGLE_FRAC_BITS + 3)'(at2_pi_lim(ANGLE_FRAC_BITS));

    // a held result stays put until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(angle))
    else $error("held output beat changed");

    // angle never leaves [-pi, +pi]
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (angle <= LIM) && (angle >= -LIM))
    else $error("angle out of range");

    // input backs up only when the output is blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid && out_stall) |-> !in_stall)
    else $error("input stalled while output free");

    // an output beat always carries known data
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !$isunknown(angle))
    else $error("unknown angle on output beat");

endmodule

bind atan2_polynomial_approx_top at2_checker #(
    .IN_WIDTH        (IN_WIDTH),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
) u_at2_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .angle     (angle)
);
